/* sv/sorted_array_priority_queue_assert.svh */
// ----------------------------------------------------------------------------
// sorted array priority queue assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SAPQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the following cycle
`define SAPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* sv/sapq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapq_pkg
// command and status codes and cell control type for the priority queue
// ----------------------------------------------------------------------------
package sapq_pkg;

    // width of the reported entry count field
    localparam int COUNT_FIELD_W = 8;

    // command codes
    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } t_cmd;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctrl;

endpackage

/* sv/sapq_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapq_in_if
// command channel: valid/ready handshake with enqueue/dequeue payload
// ----------------------------------------------------------------------------
interface sapq_in_if #(
    parameter int VALUE_WIDTH    = 16,
    parameter int PRIORITY_WIDTH = 8
);
    import sapq_pkg::*;

    logic                             valid;
    logic                             ready;
    t_cmd                             command;
    logic signed [VALUE_WIDTH-1:0]    item_value;
    logic        [PRIORITY_WIDTH-1:0] item_priority;

    modport source (output valid, command, item_value, item_priority, input ready);
    modport sink   (input valid, command, item_value, item_priority, output ready);
endinterface

/* sv/sapq_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapq_out_if
// result channel: valid/ready handshake with head value, status and count
// ----------------------------------------------------------------------------
interface sapq_out_if #(
    parameter int VALUE_WIDTH = 16
);
    import sapq_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] head_value;
    t_status                       status;
    logic [COUNT_FIELD_W-1:0]      entry_count;
    logic                          is_empty;
    logic                          is_full;

    modport source (output valid, head_value, status, entry_count, is_empty, is_full,
                    input ready);
    modport sink   (input valid, head_value, status, entry_count, is_empty, is_full,
                    output ready);
endinterface

/* sv/sorted_array_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_array_priority_queue
// shift-register priority queue built from a row of compare-and-shift cells
// ----------------------------------------------------------------------------
// Each transaction on i_in is an enqueue or a dequeue and produces exactly one
// transaction on o_out. The queue takes one transaction per clock while i_in
// is ready: all cells compare against the incoming priority and shift in
// parallel, so an insert or a remove does not wait on the fill level.
// Results sit in one output register; i_in is ready whenever that register
// is empty or is being drained in the same cycle, so with o_out.ready held
// high the queue sustains one transaction per cycle. Entries with equal
// priority leave in arrival order. An enqueue on a full queue and a dequeue
// on an empty queue leave the contents untouched and report a status code.
// Synchronous active-low reset only clears the entry count and output valid;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue #(
    parameter int DEPTH          = 128,
    parameter int VALUE_WIDTH    = 16,
    parameter int PRIORITY_WIDTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sapq_in_if.sink           i_in,
    sapq_out_if.source        o_out
);
    import sapq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > COUNT_FIELD_W) ? CW : COUNT_FIELD_W;

    // entry count and output register
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;
    logic                          r_out_valid;
    logic signed [VALUE_WIDTH-1:0] r_head;
    t_status                       r_status;
    logic [COUNT_FIELD_W-1:0]      r_entry_count;
    logic                          r_is_empty;
    logic                          r_is_full;

    // chain wiring
    logic                      w_gt    [DEPTH];
    logic [VALUE_WIDTH-1:0]    w_value [DEPTH];
    logic [PRIORITY_WIDTH-1:0] w_prio  [DEPTH];

    logic       accept;
    logic       full;
    logic       empty;
    logic       enq_ok;
    logic       deq_ok;
    t_cell_ctrl ctrl;
    t_status    n_status;
    logic [EW-1:0] count_ext;

    // handshake and command decode
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);
    assign enq_ok     = accept && (i_in.command == CMD_ENQ) && !full;
    assign deq_ok     = accept && (i_in.command == CMD_DEQ) && !empty;
    assign ctrl.enq   = enq_ok;
    assign ctrl.deq   = deq_ok;

    // next count and status
    always_comb begin
        n_count  = r_count;
        n_status = ST_DONE;
        if (enq_ok) begin
            n_count = r_count + CW'(1);
        end else if (deq_ok) begin
            n_count = r_count - CW'(1);
        end
        if (i_in.command == CMD_ENQ) begin
            if (full) n_status = ST_FULL;
        end else begin
            if (empty) n_status = ST_EMPTY;
        end
    end

    assign count_ext = EW'(n_count);

    // row of cells
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        localparam int LEFT  = (k == 0) ? 0 : k - 1;
        localparam int RIGHT = (k == DEPTH - 1) ? k : k + 1;

        sapq_cell #(
            .VALUE_WIDTH    (VALUE_WIDTH),
            .PRIORITY_WIDTH (PRIORITY_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_occupied    (CW'(k) < r_count),
            .i_at_tail     (CW'(k) == r_count),
            .i_new_value   (i_in.item_value),
            .i_new_prio    (i_in.item_priority),
            .i_left_gt     ((k == 0) ? 1'b0 : w_gt[LEFT]),
            .i_left_value  (w_value[LEFT]),
            .i_left_prio   (w_prio[LEFT]),
            .i_right_value (w_value[RIGHT]),
            .i_right_prio  (w_prio[RIGHT]),
            .o_gt          (w_gt[k]),
            .o_value       (w_value[k]),
            .o_prio        (w_prio[k])
        );
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_head        <= deq_ok ? w_value[0] : '0;
            r_status      <= n_status;
            r_entry_count <= count_ext[COUNT_FIELD_W-1:0];
            r_is_empty    <= (n_count == '0);
            r_is_full     <= (n_count == CW'(DEPTH));
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.head_value  = r_head;
    assign o_out.status      = r_status;
    assign o_out.entry_count = r_entry_count;
    assign o_out.is_empty    = r_is_empty;
    assign o_out.is_full     = r_is_full;

    // checks
`include "sorted_array_priority_queue_assert.svh"

    `SAPQ_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CW'(DEPTH), "entry count above depth")
    `SAPQ_ASSERT_SAME(a_head_sorted, r_count >= CW'(2), w_prio[0] <= w_prio[1], "head out of order")
    `SAPQ_ASSERT_NEXT(a_full_hold, accept && full && i_in.command == CMD_ENQ, $stable(r_count), "full enqueue changed count")
    `SAPQ_ASSERT_NEXT(a_result_loaded, accept, r_out_valid, "accepted transaction gave no result")

endmodule

/* sv/sapq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapq_cell
// one slot of the sorted chain: holds a value and priority, shifts toward
// the tail on insert and toward the head on remove
// ----------------------------------------------------------------------------
module sapq_cell #(
    parameter int VALUE_WIDTH    = 16,
    parameter int PRIORITY_WIDTH = 8
) (
    input  logic                      i_clk,
    input  sapq_pkg::t_cell_ctrl      i_ctrl,
    input  logic                      i_occupied,
    input  logic                      i_at_tail,
    input  logic [VALUE_WIDTH-1:0]    i_new_value,
    input  logic [PRIORITY_WIDTH-1:0] i_new_prio,
    input  logic                      i_left_gt,
    input  logic [VALUE_WIDTH-1:0]    i_left_value,
    input  logic [PRIORITY_WIDTH-1:0] i_left_prio,
    input  logic [VALUE_WIDTH-1:0]    i_right_value,
    input  logic [PRIORITY_WIDTH-1:0] i_right_prio,
    output logic                      o_gt,
    output logic [VALUE_WIDTH-1:0]    o_value,
    output logic [PRIORITY_WIDTH-1:0] o_prio
);
    import sapq_pkg::*;

    logic [VALUE_WIDTH-1:0]    r_value;
    logic [PRIORITY_WIDTH-1:0] r_prio;
    logic [VALUE_WIDTH-1:0]    n_value;
    logic [PRIORITY_WIDTH-1:0] n_prio;

    // stored entry has a larger priority number than the incoming one
    assign o_gt = i_occupied && (i_new_prio < r_prio);

    // next slot contents
    always_comb begin
        n_value = r_value;
        n_prio  = r_prio;
        if (i_ctrl.enq) begin
            if (i_left_gt) begin
                n_value = i_left_value;
                n_prio  = i_left_prio;
            end else if (o_gt || i_at_tail) begin
                n_value = i_new_value;
                n_prio  = i_new_prio;
            end
        end else if (i_ctrl.deq) begin
            n_value = i_right_value;
            n_prio  = i_right_prio;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
    end

    assign o_value = r_value;
    assign o_prio  = r_prio;

endmodule
